### src/omni_pkg.sv
// omni_wheel_mixer package: item types, wheel constants and cosine table builder
`timescale 1ns / 1ps
`default_nettype none
package omni_pkg;

  localparam int HEADING_W = 10;
  localparam int SPEED_W   = 8;
  localparam int CORR_W    = 16;
  localparam int DUTY_W    = 8;

  localparam int NUM_WHEELS   = 4;
  localparam int FULL_TURN    = 720;
  localparam int HALF_TURN    = 360;
  localparam int QUARTER_TURN = 180;
  localparam int ROM_IDX_W    = 8;
  localparam int TURN_SUM_W   = 11;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  // wheel order: left front, right front, right rear, left rear
  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_BR = 2;
  localparam int WHEEL_BL = 3;

  // mounting angles in half degrees: 322.5, 37.5, 142.5, 217.5
  localparam logic [HEADING_W-1:0] WHEEL_OFFSET [NUM_WHEELS] =
    '{10'd645, 10'd75, 10'd285, 10'd435};

  // 1 where the rotation correction is added, 0 where it is subtracted
  localparam logic [NUM_WHEELS-1:0] WHEEL_CORR_ADD = 4'b0101;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef struct packed {
    logic        [HEADING_W-1:0] heading_half_deg;
    logic        [SPEED_W-1:0]   drive_speed;
    logic signed [CORR_W-1:0]    rotation_correction;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_front_duty;
    logic              left_front_forward;
    logic [DUTY_W-1:0] right_front_duty;
    logic              right_front_forward;
    logic [DUTY_W-1:0] right_rear_duty;
    logic              right_rear_forward;
    logic [DUTY_W-1:0] left_rear_duty;
    logic              left_rear_forward;
  } out_item_t;

  // quarter-wave cosine entry, evaluated at elaboration only
  function automatic longint unsigned cos_entry(input int k, input int frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          v;
    x    = (longint'(k) * PI_Q30 + 64'd180) / 64'd360;
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    acc  = longint'(Q30_ONE);
    // twelve series terms, divisor (2n-1)*2n for term n
    term = ((term * x2) >> 30) / 64'd2;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd132;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd182;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd240;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd306;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd380;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd462;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd552;
    acc  = acc + longint'(term);
    if (acc < 0) begin
      acc = 0;
    end
    v = (acc + (longint'(1) << (29 - frac))) >>> (30 - frac);
    if (k == 0) begin
      v = longint'(1) << frac;
    end
    if (k == QUARTER_TURN) begin
      v = 0;
    end
    return longint'(v);
  endfunction

endpackage
`default_nettype wire

### src/omni_if.sv
// omni_wheel_mixer channel interfaces: command input and wheel result output
`timescale 1ns / 1ps
`default_nettype none
interface omni_in_if;
  logic               valid;
  logic               ready;
  omni_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface omni_out_if;
  logic                valid;
  logic                ready;
  omni_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### src/omni_wheel_mixer.sv
// omni_wheel_mixer top level: four-wheel omnidirectional drive mixer
// Takes one command transfer per clock and returns one result transfer per command
// through an input register, then the cosine lookup, one multiply and one add or subtract
// per wheel, then the result register. Throughput is one command per cycle as long as
// the result side takes transfers; a stalled result register holds the input register, and
// in_ch.ready drops only when both are full. The quarter-wave cosine table (181 entries,
// COS_FRAC_BITS fraction bits) is built at elaboration and read at four places per cycle.
`timescale 1ns / 1ps
`default_nettype none
module omni_wheel_mixer #(
  parameter int COS_FRAC_BITS  = 15,
  parameter int CORR_FRAC_BITS = 6
) (
  input  wire           clk,
  input  wire           rst_n,
  omni_in_if.sink       in_ch,
  omni_out_if.source    out_ch
);

  localparam int CW       = COS_FRAC_BITS + 1;
  localparam int PW       = CW + omni_pkg::SPEED_W;
  localparam int FRAC_ALL = COS_FRAC_BITS + CORR_FRAC_BITS;
  localparam int SW       = FRAC_ALL + 18;
  localparam int NW       = omni_pkg::NUM_WHEELS;
  localparam int HW       = omni_pkg::HEADING_W;
  localparam int TW       = omni_pkg::TURN_SUM_W;
  localparam int RW       = omni_pkg::ROM_IDX_W;
  localparam int DW       = omni_pkg::DUTY_W;

  // cosine table
  logic [CW-1:0] cos_rom [omni_pkg::QUARTER_TURN+1];

  for (genvar g = 0; g <= omni_pkg::QUARTER_TURN; g++) begin : g_rom
    localparam logic [CW-1:0] COS_VAL = CW'(omni_pkg::cos_entry(g, COS_FRAC_BITS));
    assign cos_rom[g] = COS_VAL;
  end

  // handshake
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic advance;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = in_ch.valid;
    end else if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register, heading reduced to one turn
  logic [HW-1:0]                      heading_in;
  logic [HW-1:0]                      heading_r;
  logic [omni_pkg::SPEED_W-1:0]       speed_r;
  logic signed [omni_pkg::CORR_W-1:0] corr_r;

  always_comb begin
    heading_in = in_ch.payload.heading_half_deg;
    if (heading_in >= HW'(omni_pkg::FULL_TURN)) begin
      heading_in = heading_in - HW'(omni_pkg::FULL_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      heading_r <= heading_in;
      speed_r   <= in_ch.payload.drive_speed;
      corr_r    <= in_ch.payload.rotation_correction;
    end
  end

  // correction aligned to the wheel sum
  logic signed [SW-1:0] corr_term;
  assign corr_term = SW'(corr_r) <<< COS_FRAC_BITS;

  logic [DW-1:0] duty [NW];
  logic          fwd  [NW];

  for (genvar w = 0; w < NW; w++) begin : g_wheel
    logic [TW-1:0]        angle_sum;
    logic [HW-1:0]        angle;
    logic [RW-1:0]        rom_idx;
    logic                 cos_neg;
    logic [PW-1:0]        prod;
    logic signed [SW-1:0] cos_term;
    logic signed [SW-1:0] wheel_sum;
    logic [SW-1:0]        mag;
    logic [SW-1:0]        mag_int;

    always_comb begin
      angle_sum = TW'(heading_r) + TW'(omni_pkg::WHEEL_OFFSET[w]);
      if (angle_sum >= TW'(omni_pkg::FULL_TURN)) begin
        angle = HW'(angle_sum - TW'(omni_pkg::FULL_TURN));
      end else begin
        angle = HW'(angle_sum);
      end
      if (angle <= HW'(omni_pkg::QUARTER_TURN)) begin
        rom_idx = RW'(angle);
        cos_neg = 1'b0;
      end else if (angle <= HW'(omni_pkg::HALF_TURN)) begin
        rom_idx = RW'(HW'(omni_pkg::HALF_TURN) - angle);
        cos_neg = 1'b1;
      end else if (angle <= HW'(omni_pkg::HALF_TURN + omni_pkg::QUARTER_TURN)) begin
        rom_idx = RW'(angle - HW'(omni_pkg::HALF_TURN));
        cos_neg = 1'b1;
      end else begin
        rom_idx = RW'(HW'(omni_pkg::FULL_TURN) - angle);
        cos_neg = 1'b0;
      end

      prod     = PW'(cos_rom[rom_idx]) * PW'(speed_r);
      cos_term = SW'(signed'({1'b0, prod}));
      if (cos_neg) begin
        cos_term = -cos_term;
      end
      cos_term = cos_term <<< CORR_FRAC_BITS;

      if (omni_pkg::WHEEL_CORR_ADD[w]) begin
        wheel_sum = cos_term + corr_term;
      end else begin
        wheel_sum = cos_term - corr_term;
      end

      fwd[w] = !wheel_sum[SW-1];
      if (wheel_sum[SW-1]) begin
        mag = unsigned'(-wheel_sum);
      end else begin
        mag = unsigned'(wheel_sum);
      end
      mag_int = mag >> FRAC_ALL;
      if (|mag_int[SW-1:DW]) begin
        duty[w] = omni_pkg::DUTY_MAX;
      end else begin
        duty[w] = mag_int[DW-1:0];
      end
    end
  end

  // result register
  omni_pkg::out_item_t result_nxt;
  omni_pkg::out_item_t result_r;

  always_comb begin
    result_nxt.left_front_duty     = duty[omni_pkg::WHEEL_FL];
    result_nxt.left_front_forward  = fwd[omni_pkg::WHEEL_FL];
    result_nxt.right_front_duty    = duty[omni_pkg::WHEEL_FR];
    result_nxt.right_front_forward = fwd[omni_pkg::WHEEL_FR];
    result_nxt.right_rear_duty     = duty[omni_pkg::WHEEL_BR];
    result_nxt.right_rear_forward  = fwd[omni_pkg::WHEEL_BR];
    result_nxt.left_rear_duty      = duty[omni_pkg::WHEEL_BL];
    result_nxt.left_rear_forward   = fwd[omni_pkg::WHEEL_BL];
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.payload = result_r;

endmodule
`default_nettype wire
